FILE: hw/rtl/wgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wgr_pkg;

   localparam int MAX_FRAME_BITS = 32;
   localparam int TIMER_BITS     = 8;
   localparam int COUNT_BITS     = 6;
   localparam int PHASE_BITS     = 8;
   localparam int DATA_BITS      = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [COUNT_BITS-1:0] BITS_MAX = '1;

   localparam logic [COUNT_BITS-1:0] FRAME_LENGTH_RESET = COUNT_BITS'(26);
   localparam logic [PHASE_BITS-1:0] LOW_PHASE_RESET    = PHASE_BITS'(4);
   localparam logic [PHASE_BITS-1:0] HIGH_PHASE_RESET   = PHASE_BITS'(59);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_LENGTH = 2'd0,
      CSR_LOW_PHASE    = 2'd1,
      CSR_HIGH_PHASE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic d0_level;
      logic d1_level;
   } wgr_req_type;

   typedef struct packed {
      logic                 frame_ready;
      logic [DATA_BITS-1:0] frame_data;
      logic                 frame_dropped;
   } wgr_rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] frame_length;
      logic [PHASE_BITS-1:0] low_phase;
      logic [PHASE_BITS-1:0] high_phase;
   } wgr_cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/wgr_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module wgr_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [wgr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [wgr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output wgr_pkg::wgr_cfg_type                      cfg
);
   import wgr_pkg::*;

   wgr_cfg_type cfg_ff;
   wgr_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH: cfg_in.frame_length = csr_wdata[COUNT_BITS-1:0];
            CSR_LOW_PHASE:    cfg_in.low_phase    = csr_wdata[PHASE_BITS-1:0];
            CSR_HIGH_PHASE:   cfg_in.high_phase   = csr_wdata[PHASE_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length <= FRAME_LENGTH_RESET;
         cfg_ff.low_phase    <= LOW_PHASE_RESET;
         cfg_ff.high_phase   <= HIGH_PHASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/wgr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module wgr_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire wgr_pkg::wgr_req_type  item,
   input  wire wgr_pkg::wgr_cfg_type  cfg,
   output wgr_pkg::wgr_rsp_type       result
);
   import wgr_pkg::*;

   logic d0_prev_ff, d0_prev_in, d1_prev_ff, d1_prev_in;
   logic d0_wait_rise_ff, d0_wait_rise_in, d1_wait_rise_ff, d1_wait_rise_in;
   logic d0_active_ff, d0_active_in, d1_active_ff, d1_active_in;
   logic d0_armed_ff, d0_armed_in, d1_armed_ff, d1_armed_in;
   logic blank_timer_on_ff, blank_timer_on_in;
   logic timeout_on_ff, timeout_on_in;
   logic [TIMER_BITS-1:0]     tick_count_ff, tick_count_in;
   logic [MAX_FRAME_BITS-1:0] shift_data_ff, shift_data_in;
   logic [COUNT_BITS-1:0]     bits_seen_ff, bits_seen_in;

   logic fall0, rise0, fall1, rise1;
   logic take0, take1, edge_seen;
   logic [TIMER_BITS-1:0] tick_next;
   logic [TIMER_BITS-1:0] target;
   logic [COUNT_BITS-1:0] bits_inc;

   assign fall0 = d0_prev_ff & ~item.d0_level;
   assign rise0 = ~d0_prev_ff & item.d0_level;
   assign fall1 = d1_prev_ff & ~item.d1_level;
   assign rise1 = ~d1_prev_ff & item.d1_level;

   // D0 has priority; at most one edge is taken per tick.
   assign take0     = d0_armed_ff & (d0_wait_rise_ff ? rise0 : fall0);
   assign take1     = ~take0 & d1_armed_ff & (d1_wait_rise_ff ? rise1 : fall1);
   assign edge_seen = take0 | take1;

   assign tick_next = tick_count_ff + TIMER_BITS'(1);
   assign target    = (d0_active_ff | d1_active_ff) ? TIMER_BITS'(cfg.low_phase)
                                                    : TIMER_BITS'(cfg.high_phase);
   assign bits_inc  = (bits_seen_ff == BITS_MAX) ? bits_seen_ff
                                                 : bits_seen_ff + COUNT_BITS'(1);

   always_comb begin
      d0_prev_in        = item.d0_level;
      d1_prev_in        = item.d1_level;
      d0_wait_rise_in   = d0_wait_rise_ff;
      d1_wait_rise_in   = d1_wait_rise_ff;
      d0_active_in      = d0_active_ff;
      d1_active_in      = d1_active_ff;
      d0_armed_in       = d0_armed_ff;
      d1_armed_in       = d1_armed_ff;
      blank_timer_on_in = blank_timer_on_ff;
      timeout_on_in     = timeout_on_ff;
      tick_count_in     = tick_count_ff;
      shift_data_in     = shift_data_ff;
      bits_seen_in      = bits_seen_ff;
      result            = '0;

      if (edge_seen) begin
         // Every accepted edge disarms both lines and restarts the blanking timer.
         d0_armed_in       = 1'b0;
         d1_armed_in       = 1'b0;
         tick_count_in     = '0;
         blank_timer_on_in = 1'b1;
         timeout_on_in     = 1'b1;
         if ((take0 && d0_wait_rise_ff) || (take1 && d1_wait_rise_ff)) begin
            if (take0) d0_wait_rise_in = 1'b0;
            else       d1_wait_rise_in = 1'b0;
            d0_active_in = 1'b0;
            d1_active_in = 1'b0;
            bits_seen_in = bits_inc;
         end else begin
            shift_data_in = {shift_data_ff[MAX_FRAME_BITS-2:0], take1};
            if (take0) d0_wait_rise_in = 1'b1;
            else       d1_wait_rise_in = 1'b1;
            d0_active_in = take0;
            d1_active_in = take1;
         end
      end else begin
         tick_count_in = tick_next;
         if (blank_timer_on_ff && tick_next == target) begin
            if (d0_active_ff && !d1_active_ff) begin
               if (d0_wait_rise_ff) begin
                  d0_armed_in       = 1'b1;
                  blank_timer_on_in = 1'b0;
               end
            end else if (!d0_active_ff && d1_active_ff) begin
               if (d1_wait_rise_ff) begin
                  d1_armed_in       = 1'b1;
                  blank_timer_on_in = 1'b0;
               end
            end else if (!d0_active_ff && !d1_active_ff) begin
               d0_armed_in       = 1'b1;
               d1_armed_in       = 1'b1;
               blank_timer_on_in = 1'b0;
            end
         end
         // A timer wrap after an edge closes the frame.
         if (tick_next == '0 && timeout_on_ff) begin
            if (bits_seen_ff == cfg.frame_length) begin
               result.frame_ready = 1'b1;
               result.frame_data  = DATA_BITS'(shift_data_ff);
            end else begin
               result.frame_dropped = 1'b1;
            end
            bits_seen_in  = '0;
            shift_data_in = '0;
            timeout_on_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_prev_ff        <= 1'b1;
         d1_prev_ff        <= 1'b1;
         d0_wait_rise_ff   <= 1'b0;
         d1_wait_rise_ff   <= 1'b0;
         d0_active_ff      <= 1'b0;
         d1_active_ff      <= 1'b0;
         d0_armed_ff       <= 1'b1;
         d1_armed_ff       <= 1'b1;
         blank_timer_on_ff <= 1'b0;
         timeout_on_ff     <= 1'b0;
         tick_count_ff     <= '0;
         shift_data_ff     <= '0;
         bits_seen_ff      <= '0;
      end else if (step) begin
         d0_prev_ff        <= d0_prev_in;
         d1_prev_ff        <= d1_prev_in;
         d0_wait_rise_ff   <= d0_wait_rise_in;
         d1_wait_rise_ff   <= d1_wait_rise_in;
         d0_active_ff      <= d0_active_in;
         d1_active_ff      <= d1_active_in;
         d0_armed_ff       <= d0_armed_in;
         d1_armed_ff       <= d1_armed_in;
         blank_timer_on_ff <= blank_timer_on_in;
         timeout_on_ff     <= timeout_on_in;
         tick_count_ff     <= tick_count_in;
         shift_data_ff     <= shift_data_in;
         bits_seen_ff      <= bits_seen_in;
      end
   end

   a_edge_restarts_timer: assert property (@(posedge clock) disable iff (reset)
      step && edge_seen |=> tick_count_ff == '0 && !d0_armed_ff && !d1_armed_ff
                            && timeout_on_ff)
      else $error("accepted edge did not restart blanking");

   a_one_line_active: assert property (@(posedge clock) disable iff (reset)
      !(d0_active_ff && d1_active_ff))
      else $error("both lines marked active");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && (result.frame_ready || result.frame_dropped)
      |=> bits_seen_ff == '0 && shift_data_ff == '0 && !timeout_on_ff)
      else $error("frame end did not clear the frame state");

endmodule

`default_nettype wire

FILE: hw/rtl/wiegand_receiver_blanking.sv
// A tick transferred on the req channel passes through the input register, then the
// result register, before it appears on rsp.
// Throughput: one tick per cycle; the only stall comes from rsp_stall.
// Reset (synchronous, active high) restores the line and frame state, loads
// frame_length 26, low_phase 4, high_phase 59 and drops any tick in flight.
`timescale 1ns / 1ps
`default_nettype none

module wiegand_receiver_blanking (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire wgr_pkg::wgr_req_type                 req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output wgr_pkg::wgr_rsp_type                      rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [wgr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [wgr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import wgr_pkg::*;

   logic        in_valid_ff, in_valid_in;
   wgr_req_type in_data_ff;
   logic        out_valid_ff, out_valid_in;
   wgr_rsp_type out_data_ff;
   logic        advance;
   logic        step;
   wgr_cfg_type cfg;
   wgr_rsp_type result;

   // The pipeline moves whenever the result register is empty or being drained.
   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign step      = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;

   assign in_valid_in  = (req_valid & ~req_stall) | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   wgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wgr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   a_ready_or_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.frame_ready && rsp_data.frame_dropped))
      else $error("frame both emitted and dropped");

   a_data_only_with_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_ready |-> rsp_data.frame_data == '0)
      else $error("frame data without a complete frame");

   a_no_loss_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held tick lost from the input register");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import wgr_pkg::*;

   localparam int HOLD_CYCLES  = 100;
   localparam int QUIET_LIMIT  = 3000;
   localparam int MAX_REPORTS  = 200;
   localparam int TIMER_PERIOD = 1 << TIMER_BITS;

   // Tracks the line and frame state of the receiver and holds the result
   // that each transferred tick must produce.
   class frame_tracker;
      logic [COUNT_BITS-1:0]   frame_length;
      logic [PHASE_BITS-1:0]   low_phase;
      logic [PHASE_BITS-1:0]   high_phase;

      bit                      d0_prev, d1_prev;
      bit                      d0_wait_rise, d1_wait_rise;
      bit                      d0_active, d1_active;
      bit                      d0_armed, d1_armed;
      bit                      blanking, timeout_armed;
      bit [TIMER_BITS-1:0]     ticks;
      bit [MAX_FRAME_BITS-1:0] shift_reg;
      bit [COUNT_BITS-1:0]     bit_count;

      wgr_rsp_type             pending_results[$];
      int                      failures;
      int                      reports;

      function new();
         frame_length  = FRAME_LENGTH_RESET;
         low_phase     = LOW_PHASE_RESET;
         high_phase    = HIGH_PHASE_RESET;
         d0_prev       = 1'b1;
         d1_prev       = 1'b1;
         d0_wait_rise  = 1'b0;
         d1_wait_rise  = 1'b0;
         d0_active     = 1'b0;
         d1_active     = 1'b0;
         d0_armed      = 1'b1;
         d1_armed      = 1'b1;
         blanking      = 1'b0;
         timeout_armed = 1'b0;
         ticks         = '0;
         shift_reg     = '0;
         bit_count     = '0;
         failures      = 0;
         reports       = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_FRAME_LENGTH: frame_length = value[COUNT_BITS-1:0];
            CSR_LOW_PHASE:    low_phase = value[PHASE_BITS-1:0];
            CSR_HIGH_PHASE:   high_phase = value[PHASE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void flag(string msg);
         failures++;
         if (reports < MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
         end
         reports++;
      endfunction

      function void start_blanking();
         d0_armed      = 1'b0;
         d1_armed      = 1'b0;
         ticks         = '0;
         blanking      = 1'b1;
         timeout_armed = 1'b1;
      endfunction

      function void accept_fall(bit on_d1);
         shift_reg = {shift_reg[MAX_FRAME_BITS-2:0], on_d1};
         if (on_d1) d1_wait_rise = 1'b1;
         else d0_wait_rise = 1'b1;
         d0_active = !on_d1;
         d1_active = on_d1;
         start_blanking();
      endfunction

      function void accept_rise(bit on_d1);
         if (on_d1) d1_wait_rise = 1'b0;
         else d0_wait_rise = 1'b0;
         d0_active = 1'b0;
         d1_active = 1'b0;
         if (bit_count != BITS_MAX) bit_count++;
         start_blanking();
      endfunction

      // End of a blanking interval: re-arm the active line for its rising
      // edge, or both lines for falling edges when none is active.
      function void phase_reached();
         if (d0_active && !d1_active) begin
            if (d0_wait_rise) begin
               d0_armed = 1'b1;
               blanking = 1'b0;
            end
         end else if (!d0_active && d1_active) begin
            if (d1_wait_rise) begin
               d1_armed = 1'b1;
               blanking = 1'b0;
            end
         end else if (!d0_active && !d1_active) begin
            d0_armed = 1'b1;
            d1_armed = 1'b1;
            blanking = 1'b0;
         end
      endfunction

      function void note_tick(wgr_req_type tick);
         bit                    fall0, rise0, fall1, rise1, took_edge;
         logic [PHASE_BITS-1:0] target;
         wgr_rsp_type           result;
         fall0     = d0_prev && !tick.d0_level;
         rise0     = !d0_prev && tick.d0_level;
         fall1     = d1_prev && !tick.d1_level;
         rise1     = !d1_prev && tick.d1_level;
         took_edge = 1'b0;
         result    = '0;
         // D0 is looked at first; at most one edge counts per tick.
         if (d0_armed && (d0_wait_rise ? rise0 : fall0)) begin
            if (d0_wait_rise) accept_rise(1'b0);
            else accept_fall(1'b0);
            took_edge = 1'b1;
         end else if (d1_armed && (d1_wait_rise ? rise1 : fall1)) begin
            if (d1_wait_rise) accept_rise(1'b1);
            else accept_fall(1'b1);
            took_edge = 1'b1;
         end
         d0_prev = tick.d0_level;
         d1_prev = tick.d1_level;
         if (!took_edge) begin
            ticks++;
            if (blanking) begin
               target = (d0_active || d1_active) ? low_phase : high_phase;
               if (ticks == target[TIMER_BITS-1:0]) phase_reached();
            end
            if (ticks == '0 && timeout_armed) begin
               if (bit_count == frame_length) begin
                  result.frame_ready = 1'b1;
                  result.frame_data  = shift_reg[DATA_BITS-1:0];
               end else begin
                  result.frame_dropped = 1'b1;
               end
               bit_count     = '0;
               shift_reg     = '0;
               timeout_armed = 1'b0;
            end
         end
         pending_results.push_back(result);
      endfunction

      function void check_result(wgr_rsp_type actual);
         wgr_rsp_type want;
         if (pending_results.size() == 0) begin
            flag($sformatf("result with nothing expected: expected none, actual %h", actual));
            return;
         end
         want = pending_results.pop_front();
         if (actual.frame_ready !== want.frame_ready) begin
            flag($sformatf("frame_ready mismatch: expected %b, actual %b",
                           want.frame_ready, actual.frame_ready));
         end
         if (actual.frame_data !== want.frame_data) begin
            flag($sformatf("frame_data mismatch: expected %h, actual %h",
                           want.frame_data, actual.frame_data));
         end
         if (actual.frame_dropped !== want.frame_dropped) begin
            flag($sformatf("frame_dropped mismatch: expected %b, actual %b",
                           want.frame_dropped, actual.frame_dropped));
         end
      endfunction
   endclass

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   wgr_req_type               req_data  = '1;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   wgr_rsp_type               rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   frame_tracker tracker;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   wiegand_receiver_blanking u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Result side: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_result(rsp_data);
   end

   // The limit is far above the hold-off and any random gap.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input logic d0, input logic d1);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{d0_level: d0, d1_level: d1};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(req_data);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic apply_setting(input int length, input int low, input int high);
      wait_drained();
      write_register(CSR_FRAME_LENGTH, CSR_DATA_BITS'(length));
      write_register(CSR_LOW_PHASE, CSR_DATA_BITS'(low));
      write_register(CSR_HIGH_PHASE, CSR_DATA_BITS'(high));
      csr_valid <= 1'b0;
   endtask

   // Ticks a level must last so that the next edge lands after the phase
   // but before the timer wraps.
   function automatic int hold_ticks(int phase);
      return phase + 1 + $urandom_range(0, (phase > TIMER_PERIOD - 4) ?
                                        TIMER_PERIOD - 1 - phase : 3);
   endfunction

   // One bit on the wire: the chosen line low, then both lines high. A noisy
   // bit flips the other line for a single tick somewhere in it.
   task automatic send_bit(input bit on_d1, input int low_ticks, input int high_ticks,
                           input bit noisy);
      int   glitch_at;
      logic d0, d1;
      glitch_at = noisy ? $urandom_range(0, low_ticks + high_ticks - 1) : -1;
      for (int i = 0; i < low_ticks + high_ticks; i++) begin
         d0 = !(i < low_ticks && !on_d1);
         d1 = !(i < low_ticks && on_d1);
         if (i == glitch_at) begin
            if (on_d1) d0 = !d0;
            else d1 = !d1;
         end
         send_tick(d0, d1);
      end
   endtask

   // A frame of nbits bits. A noisy frame has glitches on the other line and
   // levels cut short before their phase ends. Silence past the timer wrap
   // ends the frame when asked for.
   task automatic send_frame(input int nbits, input bit noisy, input bit close_frame);
      int low_ticks, high_ticks;
      for (int b = 0; b < nbits; b++) begin
         low_ticks  = hold_ticks(int'(tracker.low_phase));
         high_ticks = hold_ticks(int'(tracker.high_phase));
         if (noisy && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0) low_ticks = $urandom_range(1, tracker.low_phase);
            else high_ticks = $urandom_range(1, tracker.high_phase);
         end
         send_bit($urandom_range(0, 1) == 1, low_ticks, high_ticks,
                  noisy && $urandom_range(0, 2) == 0);
      end
      if (close_frame) repeat (TIMER_PERIOD + 1) send_tick(1'b1, 1'b1);
   endtask

   // Both lines falling together, edges on disarmed lines, a rise before the
   // low phase is over and edges in the wrong direction.
   task automatic run_directed();
      bit [1:0] levels [14] = '{2'b11, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b01,
                                2'b11, 2'b10, 2'b11, 2'b01, 2'b11, 2'b01, 2'b00};
      foreach (levels[i]) send_tick(levels[i][1], levels[i][0]);
   endtask

   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 64;
      run_directed();
      apply_setting(3, 2, 4);
      holds_asked++;
      send_frame(3, 1'b0, 1'b1);

      send_idle_pct = 64;
      recv_idle_pct = 30;
      apply_setting(2, 1, 1);
      holds_asked++;
      send_frame(2, 1'b0, 1'b1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_setting($urandom_range(1, MAX_FRAME_BITS), $urandom_range(1, 8),
                    $urandom_range(1, 12));
      send_frame($urandom_range(4, 8), 1'b1, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
